### sv/llcb_pkg.sv
// Shared types and constants for the last-lines capture buffer.
package llcb_pkg;

	localparam int CHAR_W = 8;
	localparam int LC_W   = 5;

	localparam logic [CHAR_W-1:0] NEWLINE        = 8'd10;
	localparam logic [LC_W-1:0]   LINE_COUNT_RST = 5'd10;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FETCH  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [CHAR_W-1:0] char_in;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              out_valid;
		logic              out_last;
		logic              overflow_seen;
	} result_t;

	typedef struct packed {
		logic append;
		logic clear;
		logic fetch_start;
		logic meta_read;
		logic store_read;
		logic emit;
	} dp_cmd_t;

endpackage

### sv/llcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module llcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/llcb_ctrl.sv
// Controller: decodes accepted items and sequences the fetch steps.
module llcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        operation,
	output logic              busy,
	output llcb_pkg::dp_cmd_t cmd
);
	import llcb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_META = 4'b0010,
		ST_ADDR = 4'b0100,
		ST_DATA = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (operation)
						OP_APPEND: cmd.append = 1'b1;
						OP_CLEAR:  cmd.clear  = 1'b1;
						OP_FETCH: begin
							cmd.fetch_start = 1'b1;
							state_d         = ST_META;
						end
						OP_NOP: begin
						end
					endcase
				end
			end
			ST_META: begin
				cmd.meta_read = 1'b1;
				state_d       = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.store_read = 1'b1;
				state_d        = ST_DATA;
			end
			ST_DATA: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### sv/llcb_dpath.sv
// Datapath: line ring, fill and read pointers, line store and line info RAMs.
module llcb_dpath #(
	parameter int MAX_LINES  = 16,
	parameter int LINE_LIMIT = 510
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  llcb_pkg::dp_cmd_t             cmd,
	input  logic [llcb_pkg::CHAR_W-1:0]   char_in,
	input  logic                          cfg_we,
	input  logic [llcb_pkg::LC_W-1:0]     cfg_data,
	output llcb_pkg::result_t             result,
	output logic                          done
);
	import llcb_pkg::*;

	localparam int SLOT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int FILL_W = $clog2(LINE_LIMIT + 1);
	localparam int RC_W   = $clog2(LINE_LIMIT + 2);
	localparam int DEPTH  = MAX_LINES * LINE_LIMIT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int META_W = FILL_W + 1;
	localparam int CMP_W  = (CNT_W > LC_W) ? CNT_W : LC_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_LINES - 1);
	localparam logic [SLOT_W:0]   SLOT_SPAN  = (SLOT_W + 1)'(MAX_LINES);
	localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_LINES);
	localparam logic [ADDR_W-1:0] LINE_STEP  = ADDR_W'(LINE_LIMIT);
	localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_LIMIT);

	// control state
	logic [LC_W-1:0]   line_count_q;
	logic [SLOT_W-1:0] newest_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  stored_q;
	logic [FILL_W-1:0] fill_q;
	logic              skip_q;
	logic              ovf_q;
	logic              phase_q;
	logic [CNT_W-1:0]  rline_q;
	logic [RC_W-1:0]   rchar_q;
	logic [CNT_W-1:0]  k_q;
	logic              empty_q;
	logic              done_q;

	// fetch pipeline payload
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] base_s1;
	logic [FILL_W-1:0] len_s2;
	logic              trunc_s2;
	result_t           result_q;

	// append path
	logic              new_line, advance, wrap, is_nl, trunc;
	logic [SLOT_W-1:0] slot_n;
	logic [ADDR_W-1:0] base_n, store_waddr;
	logic [FILL_W-1:0] fill_inc;
	logic              wr_en;

	assign new_line    = (fill_q == '0);
	assign advance     = new_line && (stored_q != '0);
	assign wrap        = (newest_q == LAST_SLOT);
	assign slot_n      = advance ? (wrap ? '0 : newest_q + 1'b1) : newest_q;
	assign base_n      = advance ? (wrap ? '0 : base_q + LINE_STEP) : base_q;
	assign fill_inc    = fill_q + 1'b1;
	assign is_nl       = (char_in == NEWLINE);
	assign trunc       = !is_nl && (fill_inc >= FILL_LIMIT);
	assign store_waddr = base_n + ADDR_W'(fill_q);
	assign wr_en       = cmd.append && !skip_q;

	// fetch setup
	logic [CNT_W-1:0]  rline_eff, k_now, diff_full;
	logic [RC_W-1:0]   rchar_eff;
	logic [SLOT_W-1:0] diff;
	logic [SLOT_W:0]   slot_wide;
	logic [SLOT_W-1:0] slot_now;

	assign rline_eff = phase_q ? rline_q : '0;
	assign rchar_eff = phase_q ? rchar_q : '0;
	assign k_now     = (CMP_W'(line_count_q) < CMP_W'(stored_q)) ?
	                   CNT_W'(line_count_q) : stored_q;
	assign diff_full = k_now - rline_eff - CNT_W'(1);
	assign diff      = diff_full[SLOT_W-1:0];
	assign slot_wide = {1'b0, newest_q} + SLOT_SPAN - {1'b0, diff};
	assign slot_now  = (newest_q >= diff) ? (newest_q - diff) : slot_wide[SLOT_W-1:0];

	// RAMs
	logic [META_W-1:0] meta_rdata;
	logic [CHAR_W-1:0] store_rdata;
	logic [FILL_W-1:0] meta_len;
	logic              store_re;

	assign meta_len = meta_rdata[FILL_W-1:0];
	assign store_re = cmd.store_read && (RC_W'(meta_len) > rchar_q);

	llcb_ram #(.WIDTH(META_W), .DEPTH(MAX_LINES)) u_meta_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_n),
		.wdata ({trunc, fill_inc}),
		.re    (cmd.meta_read),
		.raddr (slot_q),
		.rdata (meta_rdata)
	);

	llcb_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH)) u_store_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (store_waddr),
		.wdata (char_in),
		.re    (store_re),
		.raddr (base_s1 + ADDR_W'(rchar_q)),
		.rdata (store_rdata)
	);

	// emit step
	logic [RC_W-1:0]   total, rchar_inc;
	logic              in_text, last_byte;
	logic [CHAR_W-1:0] char_sel;

	assign total     = RC_W'(len_s2) + RC_W'(trunc_s2);
	assign rchar_inc = rchar_q + 1'b1;
	assign in_text   = (rchar_q < RC_W'(len_s2));
	assign char_sel  = in_text ? store_rdata : NEWLINE;
	assign last_byte = ((rline_q + 1'b1) == k_q) && (rchar_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= LINE_COUNT_RST;
			newest_q     <= '0;
			base_q       <= '0;
			stored_q     <= '0;
			fill_q       <= '0;
			skip_q       <= 1'b0;
			ovf_q        <= 1'b0;
			phase_q      <= 1'b0;
			rline_q      <= '0;
			rchar_q      <= '0;
			k_q          <= '0;
			empty_q      <= 1'b1;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				line_count_q <= cfg_data;
			end
			if (cmd.clear) begin
				newest_q <= '0;
				base_q   <= '0;
				stored_q <= '0;
				fill_q   <= '0;
				skip_q   <= 1'b0;
				ovf_q    <= 1'b0;
				phase_q  <= 1'b0;
				rline_q  <= '0;
				rchar_q  <= '0;
			end else if (cmd.append) begin
				phase_q <= 1'b0;
				if (skip_q) begin
					// discard the rest of an overlong line
					ovf_q <= 1'b1;
					if (is_nl) begin
						skip_q <= 1'b0;
					end
				end else begin
					newest_q <= slot_n;
					base_q   <= base_n;
					if (new_line && (stored_q != MAX_CNT)) begin
						stored_q <= stored_q + 1'b1;
					end
					fill_q <= (is_nl || trunc) ? '0 : fill_inc;
					skip_q <= trunc;
				end
			end else if (cmd.fetch_start) begin
				phase_q <= 1'b1;
				rline_q <= rline_eff;
				rchar_q <= rchar_eff;
				k_q     <= k_now;
				empty_q <= (rline_eff >= k_now);
			end else if (cmd.emit && !empty_q) begin
				if (rchar_inc >= total) begin
					rline_q <= rline_q + 1'b1;
					rchar_q <= '0;
				end else begin
					rchar_q <= rchar_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch_start) begin
			slot_q <= slot_now;
		end
		if (cmd.meta_read) begin
			base_s1 <= ADDR_W'(slot_q) * LINE_STEP;
		end
		if (cmd.store_read) begin
			len_s2   <= meta_len;
			trunc_s2 <= meta_rdata[META_W-1];
		end
		if (cmd.emit) begin
			result_q.char_out      <= empty_q ? '0 : char_sel;
			result_q.out_valid     <= !empty_q;
			result_q.out_last      <= !empty_q && last_byte;
			result_q.overflow_seen <= ovf_q;
		end
	end

	assign result = result_q;
	assign done   = done_q;
endmodule

### sv/last_lines_capture_buffer_core.sv
// Top level of the last-lines capture buffer: controller plus datapath.
//
// Usage:
//   Items enter on item (operation, char_in) and are taken at a rising edge
//   with start high and busy low. For append, clear and no-op items busy
//   stays low, so a text byte can be taken every cycle unless a fetch holds
//   busy high. A fetch item keeps busy high while the line info RAM and
//   then the line store RAM are read (each has a registered read port), and
//   the result appears on result with done high for exactly one cycle after
//   that. The receiver cannot stall; it must take the result in that cycle.
//   A new item may be started in the same cycle the result is shown.
//   The one configuration register (line_count) is written through cfg_we
//   and cfg_data, by the user only while the block is idle; the block does
//   not enforce this. It takes effect on the next fetch.
//   Reset (arst_n low) empties the ring, clears the overflow flag and the
//   readout position and sets line_count to ten. The line store needs no
//   clearing pass: only written entries are ever read back.
module last_lines_capture_buffer_core #(
	parameter int MAX_LINES  = 16,
	parameter int LINE_LIMIT = 510
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  llcb_pkg::item_t           item,
	input  logic                      cfg_we,
	input  logic [llcb_pkg::LC_W-1:0] cfg_data,
	output llcb_pkg::result_t         result,
	output logic                      done
);
	import llcb_pkg::*;

	dp_cmd_t cmd;

	// sequence fetch steps, decode append, clear and no-op items
	llcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.busy      (busy),
		.cmd       (cmd)
	);

	// hold the ring of lines and produce readout bytes
	llcb_dpath #(
		.MAX_LINES  (MAX_LINES),
		.LINE_LIMIT (LINE_LIMIT)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.char_in  (item.char_in),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

`ifndef ASSERT_OFF
	a_fetch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_FETCH) |-> ##4 done)
		else $error("fetch item did not deliver a result after four cycles");

	a_other_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation != OP_FETCH) |=> !done)
		else $error("result strobe after a non-fetch item");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a fetch in progress");

	a_exhausted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.out_valid) |-> (result.char_out == '0 && !result.out_last))
		else $error("exhausted readout carries a byte or last mark");
`endif
endmodule

### sim/tb_top.sv
// Self-checking testbench for the last-lines capture buffer core.
module tb_top;
	import llcb_pkg::*;

	// Block geometry; must match the parameters given to u_top.
	localparam int MAX_LINES      = 16;
	localparam int LINE_LIMIT     = 510;
	// Cycles from a fetch being taken to the edge that takes its result.
	localparam int FETCH_LATENCY  = 4;
	// Cycles with neither an item taken nor a result shown before giving up.
	localparam int WATCHDOG_LIMIT = 2000;
	// Mismatches reported in full; later ones are only counted.
	localparam int REPORT_LIMIT   = 10;
	// Fetches allowed in one drain of the readout.
	localparam int READOUT_CAP    = 600;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            start    = 1'b0;
	logic            busy;
	item_t           item     = '0;
	logic            cfg_we   = 1'b0;
	logic [LC_W-1:0] cfg_data = '0;
	result_t         result;
	logic            done;

	last_lines_capture_buffer_core #(
		.MAX_LINES (MAX_LINES),
		.LINE_LIMIT(LINE_LIMIT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.result  (result),
		.done    (done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Tail predictor: ring of line slots, fill position, discard state,
	// sticky overflow and the readout position.
	// ------------------------------------------------------------------
	logic [CHAR_W-1:0] text_mem [MAX_LINES*LINE_LIMIT];
	logic [8:0]        slot_len [MAX_LINES];
	logic              slot_trunc [MAX_LINES];
	logic [3:0]        head_slot;
	logic [4:0]        kept_lines;
	logic [8:0]        fill_len;
	logic              discarding;
	logic              overflow_q;
	logic              reading;
	logic [4:0]        rd_line;
	logic [9:0]        rd_char;
	logic [LC_W-1:0]   shown_lines;

	// Expected readout bytes, oldest first, and the newest one predicted.
	result_t readout_q[$];
	result_t last_readout;
	result_t want;

	int mismatch_count = 0;
	int idle_pct       = 0;
	int items_sent     = 0;
	int stall_cycles   = 0;

	// Drop every line and rewind; line_count survives a clear.
	function automatic void tail_clear();
		head_slot  = '0;
		kept_lines = '0;
		fill_len   = '0;
		discarding = 1'b0;
		overflow_q = 1'b0;
		reading    = 1'b0;
		rd_line    = '0;
		rd_char    = '0;
	endfunction

	function automatic void tail_append(input logic [CHAR_W-1:0] ch);
		// Any append ends the current readout.
		reading = 1'b0;
		// Swallow the rest of an over-long line up to its newline.
		if (discarding) begin
			overflow_q = 1'b1;
			if (ch == NEWLINE)
				discarding = 1'b0;
			return;
		end
		// First byte of a line claims the next slot, overwriting the oldest.
		if (fill_len == 0) begin
			if (kept_lines != 0)
				head_slot = 4'((head_slot + 1) % MAX_LINES);
			if (kept_lines < MAX_LINES)
				kept_lines++;
		end
		text_mem[head_slot*LINE_LIMIT + fill_len] = ch;
		fill_len++;
		slot_len[head_slot]   = fill_len;
		slot_trunc[head_slot] = 1'b0;
		if (ch == NEWLINE) begin
			fill_len = '0;
		end else if (fill_len >= LINE_LIMIT) begin
			// Full slot: close the line as truncated and skip to the newline.
			slot_trunc[head_slot] = 1'b1;
			discarding            = 1'b1;
			fill_len              = '0;
		end
	endfunction

	function automatic result_t tail_fetch();
		int      shown;
		int      slot;
		int      len;
		int      total;
		result_t r;
		shown = (shown_lines > MAX_LINES) ? MAX_LINES : int'(shown_lines);
		if (shown > kept_lines)
			shown = int'(kept_lines);
		if (!reading) begin
			reading = 1'b1;
			rd_line = '0;
			rd_char = '0;
		end
		r               = '0;
		r.overflow_seen = overflow_q;
		// Position past the shown lines reads as exhausted.
		if (rd_line >= shown)
			return r;
		slot  = (head_slot + MAX_LINES - (shown - 1 - rd_line)) % MAX_LINES;
		len   = int'(slot_len[slot]);
		// A truncated line gets a newline appended on readout.
		total = len + (slot_trunc[slot] ? 1 : 0);
		r.char_out  = (rd_char < len) ? text_mem[slot*LINE_LIMIT + rd_char] : NEWLINE;
		r.out_valid = 1'b1;
		r.out_last  = (rd_line + 1 == shown) && (rd_char + 1 >= total);
		rd_char++;
		if (rd_char >= total) begin
			rd_line++;
			rd_char = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: every strobe must match the oldest pending byte.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (readout_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result with no fetch pending: char %02h valid %b last %b ovf %b",
						result.char_out, result.out_valid, result.out_last,
						result.overflow_seen);
			end else begin
				want = readout_q.pop_front();
				if (result.char_out !== want.char_out || result.out_valid !== want.out_valid ||
						result.out_last !== want.out_last ||
						result.overflow_seen !== want.overflow_seen) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("readout mismatch: expected char %02h valid %b last %b ovf %b,",
							want.char_out, want.out_valid, want.out_last, want.overflow_seen,
							" got char %02h valid %b last %b ovf %b",
							result.char_out, result.out_valid, result.out_last,
							result.overflow_seen);
				end
			end
		end
	end

	// Abort when nothing moves for too long: a lost result or a stuck busy.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Item driver. Drive on the falling edge, hold until the rising edge
	// with busy low, then advance the predictor. Start stays high into
	// the next call so back-to-back items need no extra cycle.
	// ------------------------------------------------------------------
	task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= '{operation: op, char_in: ch};
		do @(posedge clk); while (busy);
		if (op != OP_NOP)
			items_sent++;
		case (op)
			OP_APPEND: tail_append(ch);
			OP_FETCH: begin
				last_readout = tail_fetch();
				readout_q.push_back(last_readout);
			end
			OP_CLEAR: tail_clear();
			default: ;
		endcase
	endtask

	// Drop start and hold off until every pending byte has been checked,
	// then let the pipeline settle.
	task automatic drain_readout();
		@(negedge clk);
		start <= 1'b0;
		while (readout_q.size() != 0)
			@(negedge clk);
		repeat (FETCH_LATENCY + 2) @(negedge clk);
	endtask

	// Write line_count only once the block is idle.
	task automatic write_line_count(input logic [LC_W-1:0] value);
		drain_readout();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		shown_lines = value;
	endtask

	// Random text byte other than newline.
	function automatic logic [CHAR_W-1:0] text_byte();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_W'($urandom_range(254));
		return (ch >= NEWLINE) ? ch + 8'd1 : ch;
	endfunction

	task automatic send_line(input int len, input bit terminate);
		repeat (len) send_item(OP_APPEND, text_byte());
		if (terminate)
			send_item(OP_APPEND, NEWLINE);
	endtask

	// Fetch through the end of the readout, including one exhausted fetch.
	task automatic read_all();
		int n;
		n = 0;
		do begin
			send_item(OP_FETCH, CHAR_W'($urandom));
			n++;
		end while (last_readout.out_valid && n < READOUT_CAP);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short directed pass at the reset line_count: extreme bytes, every
	// operation, unterminated final line, restart, exhaustion and clear.
	task automatic test_basic_readout();
		// Empty ring: exhausted from the first fetch.
		send_item(OP_FETCH, 8'h00);
		send_item(OP_APPEND, 8'h00);
		send_item(OP_APPEND, 8'hFF);
		send_item(OP_APPEND, NEWLINE);
		// Final line without a newline still counts as a line.
		send_item(OP_APPEND, 8'h41);
		repeat (2) send_item(OP_FETCH, 8'hFF);
		// Append in the middle of a readout restarts it from the oldest line.
		send_item(OP_APPEND, 8'h7E);
		repeat (6) send_item(OP_FETCH, 8'h00);
		// No-op must leave the exhausted readout alone.
		send_item(OP_NOP, 8'hAA);
		send_item(OP_FETCH, 8'h55);
		// Clear drops every line.
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_FETCH, 8'h00);
		send_item(OP_APPEND, 8'h55);
		send_item(OP_APPEND, NEWLINE);
		repeat (3) send_item(OP_FETCH, 8'h00);
	endtask

	// A line of exactly the limit is truncated; the newline right after it
	// is discarded and raises the overflow flag.
	task automatic test_line_at_limit();
		write_line_count(5'd2);
		send_item(OP_CLEAR, 8'h00);
		send_line(LINE_LIMIT, 1'b1);
		send_line(2, 1'b1);
		read_all();
	endtask

	// More lines than slots, then line_count changed mid-readout: down to
	// one, up past the slot count, and down to zero.
	task automatic test_count_change();
		write_line_count(5'd16);
		send_item(OP_CLEAR, 8'h00);
		repeat (MAX_LINES + 2) send_line($urandom_range(3), 1'b1);
		repeat (5) send_item(OP_FETCH, CHAR_W'($urandom));
		write_line_count(5'd1);
		repeat (3) send_item(OP_FETCH, CHAR_W'($urandom));
		write_line_count(5'd31);
		repeat (3) send_item(OP_FETCH, CHAR_W'($urandom));
		write_line_count(5'd0);
		repeat (2) send_item(OP_FETCH, CHAR_W'($urandom));
	endtask

	// Mostly well-formed lines and readouts with random content, plus raw
	// noise and the odd clear. Rarely a line near or past the limit.
	task automatic test_random_traffic(input int pct, input logic [LC_W-1:0] count,
			input int n_items);
		int first;
		int pick;
		int len;
		idle_pct = pct;
		write_line_count(count);
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				if ($urandom_range(99) == 0)
					len = $urandom_range(LINE_LIMIT + 3, LINE_LIMIT - 2);
				else
					len = $urandom_range(12);
				send_line(len, $urandom_range(9) != 0);
			end else if (pick < 65) begin
				read_all();
			end else if (pick < 85) begin
				repeat ($urandom_range(12, 1)) send_item(OP_FETCH, CHAR_W'($urandom));
			end else if (pick < 97) begin
				send_item(op_t'($urandom_range(3)), CHAR_W'($urandom));
			end else begin
				send_item(OP_CLEAR, CHAR_W'($urandom));
			end
		end
	endtask

	initial begin
		tail_clear();
		shown_lines = LINE_COUNT_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 17;
		test_basic_readout();
		test_line_at_limit();
		test_count_change();
		test_random_traffic(17, 5'd7, 170);
		test_random_traffic(63, 5'd31, 170);
		test_random_traffic(0, 5'd16, 170);
		test_random_traffic(0, LC_W'($urandom_range(31)), 170);

		// Hold off until the last fetch is checked, then report.
		drain_readout();
		if (mismatch_count == 0 && readout_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
